// ----- design/lob_pkg.sv -----
`timescale 1ns / 1ps
package lob_pkg;

  // Command codes of an input item.
  localparam logic [1:0] CMD_ADD     = 2'd0;
  localparam logic [1:0] CMD_FULFILL = 2'd1;
  localparam logic [1:0] CMD_BEST    = 2'd2;
  localparam logic [1:0] CMD_PEEK    = 2'd3;

  // Status codes of a result item.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_BOOK   = 3'd1;
  localparam logic [2:0] ST_EMPTY     = 3'd2;
  localparam logic [2:0] ST_NO_CROSS  = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_NOT_FOUND = 3'd5;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [1:0]  symbol;
    logic        side;
    logic [7:0]  price_ticks;
    logic [31:0] order_id;
  } lob_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  best_price;
    logic [31:0] head_id;
    logic [4:0]  level_count;
  } lob_rsp_t;

endpackage

// ----- design/lob_if.sv -----
`timescale 1ns / 1ps
interface lob_req_if;
  import lob_pkg::*;
  logic     valid;
  logic     ready;
  lob_req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface lob_rsp_if;
  import lob_pkg::*;
  logic     valid;
  logic     ready;
  lob_rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- design/limit_order_book.sv -----
`timescale 1ns / 1ps
// Steps from input accept to result valid: add reads its level and writes it back, peek
// reads its level and then the head slot, fulfill reads its level, searches the slots, then
// does one read and one write per shifted slot, and a best-price query reads one mark per cycle.
// Throughput: one item at a time; the next item is taken no earlier than the result leaves.
// Reset: a clearing pass zeroes the level memory before the first item is taken.
module limit_order_book #(
  parameter int NUM_SYMBOLS  = 4,
  parameter int PRICE_LEVELS = 256,
  parameter int LEVEL_DEPTH  = 16,
  parameter int ID_BITS      = 32
) (
  input logic clk_i,
  input logic rst_ni,
  lob_req_if.sink   req,
  lob_rsp_if.source rsp
);
  import lob_pkg::*;

  localparam int SYM_W   = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
  localparam int PR_W    = $clog2(PRICE_LEVELS);
  localparam int LV_NUM  = NUM_SYMBOLS * 2 * PRICE_LEVELS;
  localparam int LV_W    = $clog2(LV_NUM);
  localparam int POS_W   = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
  localparam int FILL_W  = $clog2(LEVEL_DEPTH + 1);
  localparam int SL_W    = LV_W + POS_W;
  localparam int SL_NUM  = LV_NUM * LEVEL_DEPTH;
  localparam int KEEP_W  = (ID_BITS < 32) ? ID_BITS : 32;

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_LVRD  = 10'b0000000100,
    S_LVOP  = 10'b0000001000,
    S_SRCH  = 10'b0000010000,
    S_SHIFT = 10'b0000100000,
    S_SHWR  = 10'b0001000000,
    S_SCAN  = 10'b0010000000,
    S_SCWT  = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_e;

  // Level memory entry: occupancy mark and fill count.
  typedef struct packed {
    logic              mark;
    logic [FILL_W-1:0] fill;
  } lvl_t;

  logic [FILL_W:0]   lv_mem [LV_NUM];
  logic [ID_BITS-1:0] sl_mem [SL_NUM];

  state_e state_q, state_d;
  logic [NUM_SYMBOLS-1:0] book_q, book_d;
  lob_req_t req_q, req_d;
  logic [PR_W-1:0] price_q, price_d;
  logic [ID_BITS-1:0] id_q, id_d;
  logic [LV_W-1:0] lv_q, lv_d;
  lvl_t lvl_q, lvl_d;
  logic [FILL_W-1:0] pos_q, pos_d;
  logic [PR_W-1:0] scan_q, scan_d;
  logic [PR_W:0] cnt_q, cnt_d;
  logic rsp_valid_q, rsp_valid_d;
  lob_rsp_t rsp_q, rsp_d;

  // Memory port controls.
  logic lv_we, sl_we;
  logic [LV_W-1:0] lv_ra, lv_wa;
  lvl_t lv_wd, lv_rd;
  logic [SL_W-1:0] sl_ra, sl_wa;
  logic [ID_BITS-1:0] sl_wd, sl_rd;
  logic [FILL_W:0] lv_rd_raw;

  always_ff @(posedge clk_i) begin
    if (lv_we) begin
      lv_mem[lv_wa] <= lv_wd;
    end
    lv_rd_raw <= lv_mem[lv_ra];
  end
  assign lv_rd = lvl_t'(lv_rd_raw);

  always_ff @(posedge clk_i) begin
    if (sl_we) begin
      sl_mem[sl_wa] <= sl_wd;
    end
    sl_rd <= sl_mem[sl_ra];
  end

  logic [SYM_W-1:0] sym_s;
  logic sym_ok;
  logic side_s;
  assign sym_s  = SYM_W'(req_q.symbol);
  assign sym_ok = {30'd0, req_q.symbol} < NUM_SYMBOLS;
  assign side_s = req_q.side;

  function automatic logic [LV_W-1:0] lv_idx(logic [SYM_W-1:0] s, logic sd,
                                              logic [PR_W-1:0] p);
    logic [LV_W+1:0] v;
    v = ((LV_W+2)'(s) * (LV_W+2)'(2) + (LV_W+2)'(sd)) * (LV_W+2)'(PRICE_LEVELS) +
        (LV_W+2)'(p);
    return v[LV_W-1:0];
  endfunction

  function automatic logic [SL_W-1:0] sl_idx(logic [LV_W-1:0] l, logic [FILL_W-1:0] p);
    logic [SL_W+1:0] v;
    v = (SL_W+2)'(l) * (SL_W+2)'(LEVEL_DEPTH) + (SL_W+2)'(p);
    return v[SL_W-1:0];
  endfunction

  assign req.ready = (state_q == S_IDLE) && !rsp_valid_q;
  assign rsp.valid = rsp_valid_q;
  assign rsp.payload = rsp_q;

  logic [KEEP_W-1:0] id_keep;
  assign id_keep = id_q[KEEP_W-1:0];

  // Sequencer.
  always_comb begin
    state_d = state_q;
    book_d = book_q;
    req_d = req_q;
    price_d = price_q;
    id_d = id_q;
    lv_d = lv_q;
    lvl_d = lvl_q;
    pos_d = pos_q;
    scan_d = scan_q;
    cnt_d = cnt_q;
    rsp_valid_d = rsp_valid_q;
    rsp_d = rsp_q;
    lv_we = 1'b0;
    lv_wa = lv_q;
    lv_wd = lvl_q;
    lv_ra = lv_q;
    sl_we = 1'b0;
    sl_wa = sl_idx(lv_q, pos_q);
    sl_wd = id_q;
    sl_ra = sl_idx(lv_q, pos_q);
    if (rsp_valid_q && rsp.ready) begin
      rsp_valid_d = 1'b0;
    end
    case (state_q)
      S_CLEAR: begin
        lv_we = 1'b1;
        lv_wd = '0;
        lv_d = lv_q + 1'b1;
        if (lv_q == LV_W'(LV_NUM - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req.valid && req.ready) begin
          req_d = req.payload;
          if ({24'd0, req.payload.price_ticks} >= PRICE_LEVELS) begin
            price_d = PR_W'(PRICE_LEVELS - 1);
          end else begin
            price_d = PR_W'(req.payload.price_ticks);
          end
          id_d = ID_BITS'(req.payload.order_id);
          state_d = S_LVRD;
        end
      end
      S_LVRD: begin
        rsp_d = '0;
        if (!sym_ok || (req_q.cmd != CMD_ADD && !book_q[sym_s])) begin
          rsp_d.status = ST_NO_BOOK;
          state_d = S_DONE;
        end else if (req_q.cmd == CMD_BEST) begin
          // Scan the opposite side, one mark per cycle.
          scan_d = side_s ? PR_W'(PRICE_LEVELS - 1) : '0;
          cnt_d = '0;
          lv_ra = lv_idx(sym_s, ~side_s, side_s ? PR_W'(PRICE_LEVELS - 1) : '0);
          state_d = S_SCAN;
        end else begin
          lv_d = lv_idx(sym_s, (req_q.cmd == CMD_PEEK) ? ~side_s : side_s, price_q);
          lv_ra = lv_d;
          pos_d = '0;
          state_d = S_LVOP;
        end
      end
      S_LVOP: begin
        lvl_d = lv_rd;
        case (req_q.cmd)
          CMD_ADD: begin
            book_d[sym_s] = 1'b1;
            lv_we = 1'b1;
            lv_wd.mark = 1'b1;
            lv_wd.fill = lv_rd.fill;
            if (lv_rd.fill >= FILL_W'(LEVEL_DEPTH)) begin
              rsp_d.status = ST_FULL;
            end else begin
              lv_wd.fill = lv_rd.fill + 1'b1;
              sl_we = 1'b1;
              sl_wa = sl_idx(lv_q, lv_rd.fill);
            end
            state_d = S_DONE;
          end
          CMD_PEEK: begin
            if (lv_rd.fill == '0) begin
              rsp_d.status = ST_EMPTY;
              state_d = S_DONE;
            end else begin
              sl_ra = sl_idx(lv_q, '0);
              state_d = S_SRCH;
            end
          end
          default: begin
            // Fulfill: start the search at slot zero.
            if (lv_rd.fill == '0) begin
              rsp_d.status = ST_NOT_FOUND;
              lv_we = 1'b1;
              lv_wd.mark = 1'b0;
              lv_wd.fill = '0;
              state_d = S_DONE;
            end else begin
              sl_ra = sl_idx(lv_q, '0);
              state_d = S_SRCH;
            end
          end
        endcase
      end
      S_SRCH: begin
        if (req_q.cmd == CMD_PEEK) begin
          rsp_d.head_id = 32'(sl_rd[KEEP_W-1:0]);
          rsp_d.level_count = 5'(lvl_q.fill);
          state_d = S_DONE;
        end else if (sl_rd[KEEP_W-1:0] == id_keep) begin
          state_d = S_SHIFT;
          sl_ra = sl_idx(lv_q, pos_q + 1'b1);
        end else if (pos_q + 1'b1 >= lvl_q.fill) begin
          rsp_d.status = ST_NOT_FOUND;
          state_d = S_DONE;
        end else begin
          pos_d = pos_q + 1'b1;
          sl_ra = sl_idx(lv_q, pos_q + 1'b1);
        end
      end
      S_SHIFT: begin
        // pos_q holds the gap; slot pos_q+1 is being read.
        if (pos_q + 1'b1 >= lvl_q.fill) begin
          lv_we = 1'b1;
          lv_wd.fill = lvl_q.fill - 1'b1;
          lv_wd.mark = (lvl_q.fill != FILL_W'(1));
          state_d = S_DONE;
        end else begin
          // Keep reading slot pos_q+1 so its data is there for the write.
          sl_ra = sl_idx(lv_q, pos_q + 1'b1);
          state_d = S_SHWR;
        end
      end
      S_SHWR: begin
        sl_we = 1'b1;
        sl_wd = sl_rd;
        pos_d = pos_q + 1'b1;
        sl_ra = sl_idx(lv_q, pos_q + FILL_W'(2));
        state_d = S_SHIFT;
      end
      S_SCAN: begin
        // Read the first scanned mark again; its data is checked next cycle.
        lv_ra = lv_idx(sym_s, ~side_s, scan_q);
        state_d = S_SCWT;
      end
      S_SCWT: begin
        if (lv_rd.mark) begin
          if (side_s ? (scan_q < price_q) : (scan_q > price_q)) begin
            rsp_d.status = ST_NO_CROSS;
          end else begin
            rsp_d.best_price = 8'(scan_q);
          end
          state_d = S_DONE;
        end else if (cnt_q == (PR_W+1)'(PRICE_LEVELS - 1)) begin
          rsp_d.status = ST_EMPTY;
          state_d = S_DONE;
        end else begin
          scan_d = side_s ? scan_q - 1'b1 : scan_q + 1'b1;
          cnt_d = cnt_q + 1'b1;
          lv_ra = lv_idx(sym_s, ~side_s, scan_d);
          state_d = S_SCWT;
        end
      end
      S_DONE: begin
        rsp_valid_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      book_q <= '0;
      lv_q <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      book_q <= book_d;
      lv_q <= lv_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    price_q <= price_d;
    id_q <= id_d;
    lvl_q <= lvl_d;
    pos_q <= pos_d;
    scan_q <= scan_d;
    cnt_q <= cnt_d;
    rsp_q <= rsp_d;
  end

endmodule

// ----- test/tb_limit_order_book.sv -----
`timescale 1ns / 1ps
module tb_limit_order_book;
  import lob_pkg::*;

  localparam int NSYM  = 4;
  localparam int NLVL  = 256;
  localparam int DEPTH = 16;

  // Shadow copy of the book, used to predict every result item.
  class book_scoreboard;
    bit          has_book [NSYM];
    bit          marked   [NSYM*2*NLVL];
    int unsigned fill     [NSYM*2*NLVL];
    logic [31:0] slots    [NSYM*2*NLVL][DEPTH];
    lob_rsp_t    pending  [$];
    int          errors;

    function int lvl(int s, int sd, int p);
      return (s * 2 + sd) * NLVL + p;
    endfunction

    // Apply one accepted command to the shadow book and queue its result.
    function void note_request(lob_req_t r);
      lob_rsp_t o;
      int l, n, p, opp;
      bit hit;
      o = '0;
      l = lvl(r.symbol, r.side, r.price_ticks);
      opp = r.side ^ 1;
      if (r.cmd == CMD_ADD) begin
        has_book[r.symbol] = 1;
        marked[l] = 1;
        if (fill[l] >= DEPTH) o.status = ST_FULL;
        else begin
          slots[l][fill[l]] = r.order_id;
          fill[l]++;
        end
      end else if (!has_book[r.symbol]) begin
        o.status = ST_NO_BOOK;
      end else if (r.cmd == CMD_FULFILL) begin
        n = fill[l];
        o.status = ST_NOT_FOUND;
        for (int i = 0; i < n; i++) begin
          if (slots[l][i] == r.order_id) begin
            for (int j = i; j + 1 < n; j++) slots[l][j] = slots[l][j+1];
            fill[l] = n - 1;
            o.status = ST_OK;
            break;
          end
        end
        if (fill[l] == 0) marked[l] = 0;
      end else if (r.cmd == CMD_BEST) begin
        hit = 0;
        p = 0;
        if (r.side == 0) begin
          for (p = 0; p < NLVL; p++) if (marked[lvl(r.symbol, opp, p)]) begin
            hit = 1;
            break;
          end
          if (!hit) o.status = ST_EMPTY;
          else if (p > r.price_ticks) o.status = ST_NO_CROSS;
        end else begin
          for (p = NLVL - 1; p >= 0; p--) if (marked[lvl(r.symbol, opp, p)]) begin
            hit = 1;
            break;
          end
          if (!hit) o.status = ST_EMPTY;
          else if (p < r.price_ticks) o.status = ST_NO_CROSS;
        end
        if (o.status == ST_OK) o.best_price = p[7:0];
      end else begin
        l = lvl(r.symbol, opp, r.price_ticks);
        if (fill[l] == 0) o.status = ST_EMPTY;
        else begin
          o.head_id = slots[l][0];
          o.level_count = fill[l][4:0];
        end
      end
      pending = {pending, o};
    endfunction

    // Compare one result item with the oldest prediction.
    function void check_result(lob_rsp_t a);
      lob_rsp_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $time, a);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.status !== e.status || a.best_price !== e.best_price ||
          a.head_id !== e.head_id || a.level_count !== e.level_count) begin
        $display("%0t: mismatch expected %p actual %p", $time, e, a);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  lob_req_if req ();
  lob_rsp_if rsp ();
  book_scoreboard book;
  logic [31:0] ids [NSYM][2][4][$];
  bit sending_done;

  limit_order_book DUT (.clk_i(clk_i), .rst_ni(rst_ni), .req(req.sink), .rsp(rsp.source));

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
  end

  // Send one command; waits for the handshake after a random gap.
  // Valid stays high after the handshake until the next gap or stop_sending.
  task automatic send(logic [1:0] c, logic [1:0] s, logic sd, logic [7:0] p, logic [31:0] id);
    lob_req_t r;
    int gap;
    r = '{cmd: c, symbol: s, side: sd, price_ticks: p, order_id: id};
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      req.valid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    req.valid <= 1;
    req.payload <= r;
    do @(posedge clk_i); while (!req.ready);
    book.note_request(r);
  endtask

  // Drop valid after the last item of a burst.
  task automatic stop_sending();
    req.valid <= 0;
  endtask

  // Mostly a few prices near each other so levels fill, cross and empty.
  task automatic send_random();
    int k, s, sd, pi;
    logic [7:0] p;
    logic [31:0] id;
    s = $urandom_range(0, 3);
    sd = $urandom_range(0, 1);
    pi = $urandom_range(0, 3);
    p = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'(100 + pi * 3 - sd * 4);
    if ($urandom_range(0, 9) != 0) pi = pi; else pi = -1;
    k = $urandom_range(0, 9);
    if (k < 4) begin
      id = $urandom;
      send(CMD_ADD, s, sd, p, id);
      if (pi >= 0 && p == 8'(100 + pi * 3 - sd * 4)) ids[s][sd][pi] = {ids[s][sd][pi], id};
    end else if (k < 6) begin
      if (ids[s][sd][pi < 0 ? 0 : pi].size() > 0 && $urandom_range(0, 4) != 0) begin
        if (pi < 0) pi = 0;
        p = 8'(100 + pi * 3 - sd * 4);
        k = $urandom_range(0, ids[s][sd][pi].size() - 1);
        id = ids[s][sd][pi][k];
        ids[s][sd][pi].delete(k);
      end else id = $urandom;
      send(CMD_FULFILL, s, sd, p, id);
    end else if (k < 8) send(CMD_BEST, s, sd, p, $urandom);
    else send(CMD_PEEK, s, sd, p, $urandom);
  endtask

  // Result side: a random wait before each item, check on every accepted item.
  initial begin
    int gap;
    rsp.ready = 0;
    @(posedge rst_ni);
    forever begin
      gap = $urandom_range(0, 3);
      if (gap > 0) begin
        rsp.ready <= 0;
        repeat (gap) @(posedge clk_i);
      end
      rsp.ready <= 1;
      do @(posedge clk_i); while (!rsp.valid);
      book.check_result(rsp.payload);
    end
  end

  initial begin
    book = new();
    req.valid = 0;
    req.payload = '0;
    @(posedge rst_ni);
    @(posedge clk_i);
    // Directed: commands on a missing book, extremes, a full level, crosses.
    send(CMD_FULFILL, 0, 0, 0, 0);
    send(CMD_BEST, 3, 1, 255, '1);
    send(CMD_PEEK, 2, 0, 0, 0);
    send(CMD_ADD, 0, 0, 0, 32'h0);
    send(CMD_ADD, 0, 1, 255, 32'hFFFF_FFFF);
    send(CMD_BEST, 0, 0, 255, 0);
    send(CMD_BEST, 0, 0, 10, 0);
    send(CMD_BEST, 0, 1, 0, 0);
    send(CMD_BEST, 0, 1, 1, 0);
    send(CMD_PEEK, 0, 1, 0, 0);
    send(CMD_PEEK, 0, 0, 255, 0);
    send(CMD_PEEK, 0, 0, 7, 0);
    for (int i = 0; i < DEPTH + 1; i++) send(CMD_ADD, 1, 1, 50, 32'(i + 7));
    send(CMD_PEEK, 1, 0, 50, 0);
    send(CMD_FULFILL, 1, 1, 50, 32'd9);
    send(CMD_FULFILL, 1, 1, 50, 32'd9);
    send(CMD_FULFILL, 0, 0, 0, 32'h0);
    send(CMD_BEST, 0, 1, 0, 0);
    stop_sending();
    // Pause until every result has arrived.
    while (book.pending.size() != 0) @(posedge clk_i);
    for (int i = 0; i < 1700; i++) send_random();
    stop_sending();
    sending_done = 1;
  end

  initial begin
    wait (sending_done);
    while (book.pending.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (book.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #30_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
